### src/pip_pkg.sv
// Shared types and constants for the point-in-polygon crossing block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package pip_pkg;

   localparam int COORD_WIDTH_DEF = 32;

   // dz sign classes
   localparam logic [1:0] DZ_ZERO  = 2'd0;
   localparam logic [1:0] DZ_POS   = 2'd1;
   localparam logic [1:0] DZ_NEG   = 2'd2;
   localparam logic [1:0] DZ_UNDEF = 2'd3;

   // where the query point lies against one edge
   typedef enum logic [1:0] {
      SIDE_IN,
      SIDE_ON,
      SIDE_OUT
   } side_type;

   // per-edge flags that travel down the pipeline with the products
   typedef struct packed {
      logic       first;
      logic       last;
      logic [1:0] closing;
      logic       dz_zero;
      logic [1:0] cls;
      logic       at_start;
      logic       pz_eq_z0;
      logic       pz_eq_z1;
      logic       px_lt_x0;
      side_type   side_fix;
      logic       use_prod;
   } edge_info_type;

endpackage

### src/pip_if.sv
// Valid/ready channel interfaces for edge words and result words.
// Depends on pip_pkg for the default coordinate width.
`timescale 1ns / 1ps

interface pip_req_if
   import pip_pkg::*;
   #(parameter int COORD_WIDTH = COORD_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] query_x;
   logic signed [COORD_WIDTH-1:0] query_z;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_z;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_z;
   logic [1:0]                    closing_dz_class;
   logic                          first_edge;
   logic                          last_edge;

   modport source (output valid, query_x, query_z, start_x, start_z, end_x, end_z,
                   closing_dz_class, first_edge, last_edge, input ready);
   modport sink (input valid, query_x, query_z, start_x, start_z, end_x, end_z,
                 closing_dz_class, first_edge, last_edge, output ready);
endinterface

interface pip_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   logic on_boundary;

   modport source (output valid, inside_res, on_boundary, input ready);
   modport sink (input valid, inside_res, on_boundary, output ready);
endinterface

### src/pip_prep.sv
// Edge classification: side-of-segment rules up to the product compare.
// Depends on pip_pkg (side_type, edge_info_type, dz class codes).
`timescale 1ns / 1ps

module pip_prep
   import pip_pkg::*;
   #(parameter int COORD_WIDTH = COORD_WIDTH_DEF) (
   input  logic signed [COORD_WIDTH-1:0] px,
   input  logic signed [COORD_WIDTH-1:0] pz,
   input  logic signed [COORD_WIDTH-1:0] x0,
   input  logic signed [COORD_WIDTH-1:0] z0,
   input  logic signed [COORD_WIDTH-1:0] x1,
   input  logic signed [COORD_WIDTH-1:0] z1,
   input  logic [1:0]                    closing,
   input  logic                          first,
   input  logic                          last,
   output edge_info_type                 info,
   output logic [COORD_WIDTH-1:0]        a1,
   output logic [COORD_WIDTH-1:0]        b1,
   output logic [COORD_WIDTH-1:0]        a2,
   output logic [COORD_WIDTH-1:0]        b2
);

   localparam int C = COORD_WIDTH;

   logic signed [C:0] pxe, pze, x0e, z0e, x1e, z1e;
   logic signed [C:0] dxs, dzs, ndx, ndz, qx, qz;
   logic              dx_zero, dz_zero, dxp, dzp;
   logic              in_c, out_x, out_z, use_prod;
   side_type          side_fix;

   assign pxe = {px[C-1], px};
   assign pze = {pz[C-1], pz};
   assign x0e = {x0[C-1], x0};
   assign z0e = {z0[C-1], z0};
   assign x1e = {x1[C-1], x1};
   assign z1e = {z1[C-1], z1};
   assign dxs = x0e - x1e;
   assign dzs = z0e - z1e;
   assign ndx = x1e - x0e;
   assign ndz = z1e - z0e;

   always_comb begin
      dx_zero  = (x0 == x1);
      dz_zero  = (z0 == z1);
      dxp      = !dx_zero && !dxs[C];
      dzp      = !dz_zero && !dzs[C];
      side_fix = SIDE_IN;
      use_prod = 1'b0;
      in_c     = 1'b0;
      out_x    = 1'b0;
      out_z    = 1'b0;
      qx       = '0;
      qz       = '0;
      if (dx_zero) begin
         if (dzp) begin
            in_c = (pz < z1) || (pz > z0) || (px > x0);
         end else begin
            in_c = (pz < z0) || (pz > z1) || (px > x0);
         end
         side_fix = in_c ? SIDE_IN : ((px == x0) ? SIDE_ON : SIDE_OUT);
      end else if (dz_zero) begin
         if (pz != z0) begin
            side_fix = SIDE_IN;
         end else if (dxp) begin
            side_fix = (px > x0) ? SIDE_IN : ((px < x1) ? SIDE_OUT : SIDE_ON);
         end else begin
            side_fix = (px > x1) ? SIDE_IN : ((px < x0) ? SIDE_OUT : SIDE_ON);
         end
      end else begin
         // general edge: range checks, then sign of qx*|dz| - qz*|dx|
         if (dxp) begin
            out_x = px > x0;
            qx    = pxe - x1e;
         end else begin
            out_x = px > x1;
            qx    = pxe - x0e;
         end
         if (dzp) begin
            out_z = (pz < z1) || (pz > z0);
            qz    = dxp ? (pze - z1e) : (z0e - pze);
         end else begin
            out_z = (pz < z0) || (pz > z1);
            qz    = dxp ? (z1e - pze) : (pze - z0e);
         end
         if (out_x || out_z) begin
            side_fix = SIDE_IN;
         end else if (qx[C]) begin
            // qz >= 0 and |dx| > 0, so a negative qx gives a negative cross term
            side_fix = SIDE_OUT;
         end else begin
            use_prod = 1'b1;
         end
      end
   end

   assign a1 = qx[C-1:0];
   assign b1 = dzp ? dzs[C-1:0] : ndz[C-1:0];
   assign a2 = qz[C-1:0];
   assign b2 = dxp ? dxs[C-1:0] : ndx[C-1:0];

   always_comb begin
      info.first    = first;
      info.last     = last;
      info.closing  = closing;
      info.dz_zero  = dz_zero;
      info.cls      = (z1 > z0) ? DZ_POS : DZ_NEG;
      info.at_start = (pz == z0) && (px == x0);
      info.pz_eq_z0 = (pz == z0);
      info.pz_eq_z1 = (pz == z1);
      info.px_lt_x0 = (px < x0);
      info.side_fix = side_fix;
      info.use_prod = use_prod;
   end

endmodule

### src/point_in_polygon_crossing.sv
// Top level: edge pipeline, split product compare and crossing state.
// Depends on pip_pkg, pip_if (pip_req_if, pip_rsp_if) and pip_prep.
`timescale 1ns / 1ps

//  channel | dir | handshake    | word
//  req     | in  | valid/ready  | query point, one edge, closing dz class, first/last
//  rsp     | out | valid/ready  | inside_res, on_boundary (only on a last edge)
//
//  One edge word per cycle while no last edge is held in the final stage. A last
//  edge passes the input register, classification, partial products and product
//  sums registers, then compare and state update write the result register.
//  Synchronous active-high reset clears stage valids, result valid and state.
//  While a result waits, edges that are not last keep draining into the state;
//  req.ready drops only when the pipeline has filled behind the waiting result.

module point_in_polygon_crossing
   import pip_pkg::*;
   #(parameter int COORD_WIDTH = COORD_WIDTH_DEF) (
   input  logic  clock,
   input  logic  reset,
   pip_req_if.sink   req,
   pip_rsp_if.source rsp
);

   localparam int C    = COORD_WIDTH;
   localparam int LO_W = (COORD_WIDTH + 1) / 2;
   localparam int HI_W = COORD_WIDTH - LO_W;
   localparam int PW   = 2 * COORD_WIDTH;

   // stage valids and moves
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic mv1, mv2, mv3, mv4, adv4;

   // stage 1: input register
   logic signed [C-1:0] px_ff, pz_ff, x0_ff, z0_ff, x1_ff, z1_ff;
   logic [1:0]          closing_ff;
   logic                first_ff, last_ff;

   // stage 2: classification
   edge_info_type  info2_in, info2_ff;
   logic [C-1:0]   a1_in, b1_in, a2_in, b2_in;
   logic [C-1:0]   a1_ff, b1_ff, a2_ff, b2_ff;

   // stage 3: partial products
   edge_info_type          info3_ff;
   logic [2*LO_W-1:0]      ll1_in, ll2_in, ll1_ff, ll2_ff;
   logic [LO_W+HI_W-1:0]   lh1_in, lh2_in, hl1_in, hl2_in;
   logic [LO_W+HI_W-1:0]   lh1_ff, lh2_ff, hl1_ff, hl2_ff;
   logic [2*HI_W-1:0]      hh1_in, hh2_in, hh1_ff, hh2_ff;

   // stage 4: full products
   edge_info_type  info4_ff;
   logic [PW-1:0]  p1_in, p2_in, p1_ff, p2_ff;

   // crossing state and result
   logic       parity_ff, hit_ff, parity_in, hit_in;
   logic [1:0] prev_ff, prev_in;
   side_type   side;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       inside_ff, on_bnd_ff;

   // a non-last edge can always retire into the state; a last one needs the slot
   assign adv4 = v4_ff && (!info4_ff.last || !rsp_valid_ff || rsp.ready);
   assign mv4  = !v4_ff || adv4;
   assign mv3  = !v3_ff || mv4;
   assign mv2  = !v2_ff || mv3;
   assign mv1  = !v1_ff || mv2;
   assign req.ready = mv1;

   assign v1_in = mv1 ? req.valid : v1_ff;
   assign v2_in = mv2 ? v1_ff : v2_ff;
   assign v3_in = mv3 ? v2_ff : v3_ff;
   assign v4_in = mv4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && mv1) begin
         px_ff      <= req.query_x;
         pz_ff      <= req.query_z;
         x0_ff      <= req.start_x;
         z0_ff      <= req.start_z;
         x1_ff      <= req.end_x;
         z1_ff      <= req.end_z;
         closing_ff <= req.closing_dz_class;
         first_ff   <= req.first_edge;
         last_ff    <= req.last_edge;
      end
   end

   pip_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
      .px      (px_ff),
      .pz      (pz_ff),
      .x0      (x0_ff),
      .z0      (z0_ff),
      .x1      (x1_ff),
      .z1      (z1_ff),
      .closing (closing_ff),
      .first   (first_ff),
      .last    (last_ff),
      .info    (info2_in),
      .a1      (a1_in),
      .b1      (b1_in),
      .a2      (a2_in),
      .b2      (b2_in)
   );

   always_ff @(posedge clock) begin
      if (v1_ff && mv2) begin
         info2_ff <= info2_in;
         a1_ff    <= a1_in;
         b1_ff    <= b1_in;
         a2_ff    <= a2_in;
         b2_ff    <= b2_in;
      end
   end

   // half-width partial products of qx*|dz| and qz*|dx|
   always_comb begin
      ll1_in = (2*LO_W)'(a1_ff[LO_W-1:0]) * (2*LO_W)'(b1_ff[LO_W-1:0]);
      lh1_in = (LO_W+HI_W)'(a1_ff[LO_W-1:0]) * (LO_W+HI_W)'(b1_ff[C-1:LO_W]);
      hl1_in = (LO_W+HI_W)'(a1_ff[C-1:LO_W]) * (LO_W+HI_W)'(b1_ff[LO_W-1:0]);
      hh1_in = (2*HI_W)'(a1_ff[C-1:LO_W]) * (2*HI_W)'(b1_ff[C-1:LO_W]);
      ll2_in = (2*LO_W)'(a2_ff[LO_W-1:0]) * (2*LO_W)'(b2_ff[LO_W-1:0]);
      lh2_in = (LO_W+HI_W)'(a2_ff[LO_W-1:0]) * (LO_W+HI_W)'(b2_ff[C-1:LO_W]);
      hl2_in = (LO_W+HI_W)'(a2_ff[C-1:LO_W]) * (LO_W+HI_W)'(b2_ff[LO_W-1:0]);
      hh2_in = (2*HI_W)'(a2_ff[C-1:LO_W]) * (2*HI_W)'(b2_ff[C-1:LO_W]);
   end

   always_ff @(posedge clock) begin
      if (v2_ff && mv3) begin
         info3_ff <= info2_ff;
         ll1_ff   <= ll1_in;
         lh1_ff   <= lh1_in;
         hl1_ff   <= hl1_in;
         hh1_ff   <= hh1_in;
         ll2_ff   <= ll2_in;
         lh2_ff   <= lh2_in;
         hl2_ff   <= hl2_in;
         hh2_ff   <= hh2_in;
      end
   end

   assign p1_in = (PW'(hh1_ff) << (2*LO_W)) + ((PW'(lh1_ff) + PW'(hl1_ff)) << LO_W)
                + PW'(ll1_ff);
   assign p2_in = (PW'(hh2_ff) << (2*LO_W)) + ((PW'(lh2_ff) + PW'(hl2_ff)) << LO_W)
                + PW'(ll2_ff);

   always_ff @(posedge clock) begin
      if (v3_ff && mv4) begin
         info4_ff <= info3_ff;
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
      end
   end

   // compare and crossing-state update
   always_comb begin
      parity_in = parity_ff;
      hit_in    = hit_ff;
      prev_in   = prev_ff;
      if (info4_ff.first) begin
         parity_in = 1'b0;
         hit_in    = 1'b0;
         prev_in   = (info4_ff.closing == DZ_UNDEF) ? DZ_ZERO : info4_ff.closing;
      end
      if (info4_ff.use_prod) begin
         side = (p1_ff > p2_ff) ? SIDE_IN : ((p1_ff == p2_ff) ? SIDE_ON : SIDE_OUT);
      end else begin
         side = info4_ff.side_fix;
      end
      if (!hit_in) begin
         if (info4_ff.dz_zero) begin
            if (side == SIDE_ON) begin
               hit_in = 1'b1;
            end
         end else if (info4_ff.at_start) begin
            hit_in = 1'b1;
         end else if (!info4_ff.pz_eq_z0) begin
            if (!info4_ff.pz_eq_z1 && side == SIDE_ON) begin
               hit_in = 1'b1;
            end else begin
               if (!info4_ff.pz_eq_z1 && side == SIDE_OUT) begin
                  parity_in = !parity_in;
               end
               prev_in = info4_ff.cls;
            end
         end else begin
            // vertex at the query z: count only when dz agrees with the last class
            if (info4_ff.px_lt_x0 && (prev_in == DZ_ZERO || prev_in == info4_ff.cls)) begin
               parity_in = !parity_in;
            end
            prev_in = info4_ff.cls;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= 1'b0;
         hit_ff    <= 1'b0;
         prev_ff   <= DZ_ZERO;
      end else if (adv4) begin
         parity_ff <= parity_in;
         hit_ff    <= hit_in;
         prev_ff   <= prev_in;
      end
   end

   assign rsp_valid_in = (adv4 && info4_ff.last) ? 1'b1 :
                         (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv4 && info4_ff.last) begin
         inside_ff <= hit_in | parity_in;
         on_bnd_ff <= hit_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.inside_res  = inside_ff;
   assign rsp.on_boundary = on_bnd_ff;

   // a boundary hit freezes the polygon state until the next first edge
   assert property (@(posedge clock) disable iff (reset)
      hit_ff && !(adv4 && info4_ff.first) |=> hit_ff && $stable(parity_ff) && $stable(prev_ff))
      else $error("boundary latch or parity changed after a hit");

   // a retiring last edge always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      adv4 && info4_ff.last |=> rsp_valid_ff)
      else $error("last edge retired without a result");

   // a stalled final stage holds its edge
   assert property (@(posedge clock) disable iff (reset)
      v4_ff && !adv4 |=> v4_ff && $stable(info4_ff) && $stable(p1_ff))
      else $error("final stage lost a stalled edge");

endmodule

### dv/point_in_polygon_crossing_checker.sv
// Answer checker for point_in_polygon_crossing: follows the edge and answer channels,
// predicts every answer from the accepted edge words and compares it field by field.
// Depends on pip_pkg (dz classes, side_type) and pip_if (pip_req_if, pip_rsp_if).
`timescale 1ns / 1ps

module point_in_polygon_crossing_checker
   import pip_pkg::*;
(
   input  logic clock,
   input  logic reset,
   pip_req_if   req,
   pip_rsp_if   rsp,
   output int   fail_count,
   output int   open_count,
   output int   answer_count,
   output int   rim_count
);

   typedef struct packed {
      logic in_poly;
      logic on_rim;
   } answer_type;

   answer_type answer_q[$];

   // predicted crossing state
   logic       ray_parity = 1'b0;
   logic [1:0] slope_class = DZ_ZERO;  // dz class of the previous non-horizontal edge
   logic       rim_latched = 1'b0;

   int errors = 0;
   int answers = 0;
   int rim_answers = 0;

   // where (px, pz) lies against the segment (x0, z0) -> (x1, z1)
   function automatic side_type side_of_segment(longint px, longint pz, longint x0,
                                                 longint z0, longint x1, longint z1);
      longint dx, dz, adx, adz, qx, qz;
      logic signed [95:0] wqx, wqz, wdx, wdz, cross_term;
      dx = x0 - x1;
      dz = z0 - z1;
      if (dx == 0) begin
         if (dz > 0) begin
            if (pz < z1 || pz > z0 || px > x0) return SIDE_IN;
         end else begin
            if (pz < z0 || pz > z1 || px > x0) return SIDE_IN;
         end
         return (px == x0) ? SIDE_ON : SIDE_OUT;
      end
      if (dz == 0) begin
         if (pz != z0) return SIDE_IN;
         if (dx > 0) return (px > x0) ? SIDE_IN : ((px < x1) ? SIDE_OUT : SIDE_ON);
         return (px > x1) ? SIDE_IN : ((px < x0) ? SIDE_OUT : SIDE_ON);
      end
      if (dx > 0) begin
         if (px > x0) return SIDE_IN;
         qx = px - x1;
         adx = dx;
      end else begin
         if (px > x1) return SIDE_IN;
         qx = px - x0;
         adx = -dx;
      end
      // qz is measured from the vertex that qx was taken from
      if (dz > 0) begin
         if (pz < z1 || pz > z0) return SIDE_IN;
         adz = dz;
         qz = (dx > 0) ? pz - z1 : z0 - pz;
      end else begin
         if (pz < z0 || pz > z1) return SIDE_IN;
         adz = -dz;
         qz = (dx > 0) ? z1 - pz : pz - z0;
      end
      wqx = qx;
      wqz = qz;
      wdx = adx;
      wdz = adz;
      cross_term = wqx * wdz - wqz * wdx;
      if (cross_term == 0) return SIDE_ON;
      return (cross_term > 0) ? SIDE_IN : SIDE_OUT;
   endfunction

   function automatic void trace_edge(longint px, longint pz, longint x0, longint z0,
                                      longint x1, longint z1);
      longint     rise;
      logic [1:0] cls;
      side_type   side;
      rise = z1 - z0;
      if (rise == 0) begin
         if (side_of_segment(px, pz, x0, z0, x1, z1) == SIDE_ON) rim_latched = 1'b1;
         return;
      end
      cls = (rise > 0) ? DZ_POS : DZ_NEG;
      if (pz == z0 && px == x0) begin
         rim_latched = 1'b1;
      end else if (pz != z0) begin
         if (pz != z1) begin
            side = side_of_segment(px, pz, x0, z0, x1, z1);
            if (side == SIDE_OUT) begin
               ray_parity = ~ray_parity;
            end else if (side == SIDE_ON) begin
               rim_latched = 1'b1;
               return;
            end
         end
         slope_class = cls;
      end else begin
         // ray passes through the start vertex: count it only on a monotone run
         if (px < x0 && (slope_class == DZ_ZERO || slope_class == cls))
            ray_parity = ~ray_parity;
         slope_class = cls;
      end
   endfunction

   function automatic void take_word();
      answer_type fresh;
      if (req.first_edge) begin
         ray_parity = 1'b0;
         rim_latched = 1'b0;
         slope_class = (req.closing_dz_class == DZ_UNDEF) ? DZ_ZERO : req.closing_dz_class;
      end
      if (!rim_latched)
         trace_edge(req.query_x, req.query_z, req.start_x, req.start_z, req.end_x, req.end_z);
      if (req.last_edge) begin
         fresh.in_poly = rim_latched | ray_parity;
         fresh.on_rim = rim_latched;
         answer_q.insert(answer_q.size(), fresh);
      end
   endfunction

   function automatic void check_answer();
      answer_type want;
      answers++;
      if (rsp.on_boundary) rim_answers++;
      if (answer_q.size() == 0) begin
         errors++;
         $error("answer word with none pending: inside_res=%0b on_boundary=%0b",
                rsp.inside_res, rsp.on_boundary);
         return;
      end
      want = answer_q.pop_front();
      if (rsp.inside_res !== want.in_poly) begin
         errors++;
         $error("inside_res: expected %0b, actual %0b", want.in_poly, rsp.inside_res);
      end
      if (rsp.on_boundary !== want.on_rim) begin
         errors++;
         $error("on_boundary: expected %0b, actual %0b", want.on_rim, rsp.on_boundary);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         ray_parity = 1'b0;
         slope_class = DZ_ZERO;
         rim_latched = 1'b0;
         answer_q.delete();
      end else begin
         if (req.valid && req.ready) take_word();
         if (rsp.valid && rsp.ready) check_answer();
      end
      fail_count <= errors;
      open_count <= answer_q.size();
      answer_count <= answers;
      rim_count <= rim_answers;
   end

endmodule

### dv/point_in_polygon_crossing_test.sv
// Top of the point_in_polygon_crossing testbench: clock, reset, edge word stimulus,
// answer back-pressure, watchdog and verdict. Depends on pip_pkg, pip_if, the block
// and point_in_polygon_crossing_checker.
`timescale 1ns / 1ps

module point_in_polygon_crossing_test;
   import pip_pkg::*;

   localparam int     IDLE_LIMIT   = 4000;
   localparam int     RANDOM_WORDS = 680;
   localparam longint ONE          = 64'sd65536;  // 1.0 in 16.16
   localparam longint CMIN         = -64'sd2147483648;
   localparam longint CMAX         = 64'sd2147483647;

   logic clock;
   logic reset;
   int   fail_count, open_count, answer_count, rim_count;
   int   sent_words = 0;
   int   directed_words = 0;
   int   idle_cycles = 0;
   int   send_calm = 0;
   bit   drained_once = 1'b0;

   pip_req_if req_ch ();
   pip_rsp_if rsp_ch ();

   point_in_polygon_crossing dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   point_in_polygon_crossing_checker answer_check (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .fail_count   (fail_count),
      .open_count   (open_count),
      .answer_count (answer_count),
      .rim_count    (rim_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, a few long ones, and now and then a run with none
   function automatic int pick_gap();
      int r;
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         send_calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic longint any_coord();
      return longint'(int'($urandom()));
   endfunction

   task automatic send_word(input longint qx, input longint qz, input longint sx,
                            input longint sz, input longint ex, input longint ez,
                            input logic [1:0] closing, input logic head, input logic tail);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.query_x <= 32'(qx);
      req_ch.query_z <= 32'(qz);
      req_ch.start_x <= 32'(sx);
      req_ch.start_z <= 32'(sz);
      req_ch.end_x <= 32'(ex);
      req_ch.end_z <= 32'(ez);
      req_ch.closing_dz_class <= closing;
      req_ch.first_edge <= head;
      req_ch.last_edge <= tail;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_words++;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold the sender until every predicted answer has come back
   task automatic pause_for_answers();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   // one polygon on a coarse grid (or full range), mostly well formed
   task automatic random_ring();
      longint     xs[9], zs[9];
      longint     qx, qz, scale, rise;
      int         nseg, nvert, k, g, pick, mode, stop_at;
      logic [1:0] closing;
      bit         wide_mode;
      nseg = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(3, 8);
      nvert = (nseg == 1) ? 2 : nseg;
      wide_mode = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 3))
         0: scale = 1;
         1: scale = ONE;
         2: scale = 64'sd1 << 20;
         default: scale = 64'sd1 << 28;
      endcase
      for (k = 0; k < nvert; k++) begin
         g = $urandom_range(0, 8);
         xs[k] = longint'(g - 4) * scale;
         g = $urandom_range(0, 8);
         zs[k] = longint'(g - 4) * scale;
         if (wide_mode) begin
            xs[k] = any_coord();
            zs[k] = any_coord();
         end
         if (k > 0) begin
            // bias toward horizontal, vertical and zero-length edges
            case ($urandom_range(0, 5))
               0: zs[k] = zs[k - 1];
               1: xs[k] = xs[k - 1];
               2: if ($urandom_range(0, 3) == 0) begin
                  xs[k] = xs[k - 1];
                  zs[k] = zs[k - 1];
               end
               default: ;
            endcase
         end
      end
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, nvert - 1);
      if (pick < 20) begin
         qx = xs[k];
         qz = zs[k];
      end else if (pick < 40) begin
         qx = (xs[k] + xs[(k + 1) % nvert]) >>> 1;
         qz = (zs[k] + zs[(k + 1) % nvert]) >>> 1;
      end else if (wide_mode) begin
         qx = any_coord();
         qz = any_coord();
      end else begin
         g = $urandom_range(0, 10);
         qx = longint'(g - 5) * scale;
         g = $urandom_range(0, 10);
         qz = longint'(g - 5) * scale;
      end
      // class of the last non-horizontal edge, occasionally scrambled
      closing = DZ_ZERO;
      for (k = 0; k < nseg; k++) begin
         rise = zs[(k + 1) % nvert] - zs[k];
         if (rise > 0) closing = DZ_POS;
         else if (rise < 0) closing = DZ_NEG;
      end
      if ($urandom_range(0, 6) == 0) closing = 2'($urandom_range(0, 3));
      // 84 whole, 6 without first flag, 5 without last flag, 5 cut short
      mode = $urandom_range(0, 99);
      stop_at = (mode >= 95) ? $urandom_range(0, nseg - 1) : nseg - 1;
      for (k = 0; k <= stop_at; k++)
         send_word(qx, qz, xs[k], zs[k], xs[(k + 1) % nvert], zs[(k + 1) % nvert], closing,
                   k == 0 && !(mode >= 84 && mode < 90),
                   k == stop_at && !(mode >= 90 && mode < 95));
   endtask

   task automatic noise_words();
      int n, k;
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++)
         send_word(any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                   any_coord(), 2'($urandom_range(0, 3)), $urandom_range(0, 3) == 0,
                   $urandom_range(0, 2) == 0);
   endtask

   // answer back-pressure
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 9) == 0) begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(20, 100)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_ch.ready <= 1'b0;
            if ($urandom_range(0, 99) < 85) repeat ($urandom_range(1, 3)) @(posedge clock);
            else repeat ($urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no word moved on either channel for %0d cycles", IDLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.query_x <= '0;
      req_ch.query_z <= '0;
      req_ch.start_x <= '0;
      req_ch.start_z <= '0;
      req_ch.end_x <= '0;
      req_ch.end_z <= '0;
      req_ch.closing_dz_class <= DZ_ZERO;
      req_ch.first_edge <= 1'b0;
      req_ch.last_edge <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // unit square, point at the center
      send_word(0, 0, -ONE, -ONE, ONE, -ONE, DZ_NEG, 1'b1, 1'b0);
      send_word(0, 0, ONE, -ONE, ONE, ONE, DZ_NEG, 1'b0, 1'b0);
      send_word(0, 0, ONE, ONE, -ONE, ONE, DZ_NEG, 1'b0, 1'b0);
      send_word(0, 0, -ONE, ONE, -ONE, -ONE, DZ_NEG, 1'b0, 1'b1);
      // same square, point on a corner: the last edge must be ignored
      send_word(ONE, ONE, -ONE, -ONE, ONE, -ONE, DZ_NEG, 1'b1, 1'b0);
      send_word(ONE, ONE, ONE, -ONE, ONE, ONE, DZ_NEG, 1'b0, 1'b0);
      send_word(ONE, ONE, ONE, ONE, -ONE, ONE, DZ_NEG, 1'b0, 1'b0);
      send_word(ONE, ONE, -ONE, ONE, -ONE, -ONE, DZ_NEG, 1'b0, 1'b1);
      // full-range triangle, undefined closing class
      send_word(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, DZ_UNDEF, 1'b1, 1'b0);
      send_word(CMAX, CMAX, CMAX, CMIN, 0, CMAX, DZ_UNDEF, 1'b0, 1'b0);
      send_word(CMAX, CMAX, 0, CMAX, CMIN, CMIN, DZ_UNDEF, 1'b0, 1'b1);
      // zero-length edges, with the point on it and off it
      send_word(5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, DZ_ZERO, 1'b1, 1'b1);
      send_word(0, 0, ONE, 0, ONE, 0, DZ_POS, 1'b1, 1'b1);
      // edges with no first flag continue from the state after the last answer
      send_word(0, ONE / 2, -ONE, 0, -ONE, ONE, DZ_ZERO, 1'b0, 1'b0);
      send_word(0, ONE / 2, -ONE, ONE, ONE, ONE, DZ_ZERO, 1'b0, 1'b1);
      // point on a full-width horizontal edge
      send_word(0, CMAX, CMIN, CMAX, CMAX, CMAX, DZ_NEG, 1'b1, 1'b1);
      // diamond: the line at the query z runs through two vertices
      send_word(2 * ONE, 0, 0, -ONE, ONE, 0, DZ_NEG, 1'b1, 1'b0);
      send_word(2 * ONE, 0, ONE, 0, 0, ONE, DZ_NEG, 1'b0, 1'b0);
      send_word(2 * ONE, 0, 0, ONE, -ONE, 0, DZ_NEG, 1'b0, 1'b0);
      send_word(2 * ONE, 0, -ONE, 0, 0, -ONE, DZ_NEG, 1'b0, 1'b1);
      directed_words = sent_words;
      pause_for_answers();

      while (sent_words - directed_words < RANDOM_WORDS) begin
         if (!drained_once && sent_words - directed_words >= RANDOM_WORDS / 2) begin
            pause_for_answers();
            drained_once = 1'b1;
         end
         if ($urandom_range(0, 99) < 85) random_ring();
         else noise_words();
      end

      pause_for_answers();
      repeat (20) @(posedge clock);
      $display("Summary: %0d edge words sent, %0d directed, rest random polygons and noise",
               sent_words, directed_words);
      $display("Summary: %0d answers checked, %0d of them boundary hits",
               answer_count, rim_count);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### sim.f
src/pip_pkg.sv
src/pip_if.sv
src/pip_prep.sv
src/point_in_polygon_crossing.sv
dv/point_in_polygon_crossing_checker.sv
dv/point_in_polygon_crossing_test.sv
